/* hdl/iss_pkg.sv */
// Shared types and constants for the interval set selection table.
// No dependencies; compiled first.
package iss_pkg;

    localparam int CMD_W    = 3;
    localparam int FIELD_W  = 24;
    localparam int STATUS_W = 2;
    localparam int TOTAL_W  = 25;

    typedef enum logic [CMD_W-1:0] {
        CMD_SELECT     = 3'd0,
        CMD_DESELECT   = 3'd1,
        CMD_QUERY      = 3'd2,
        CMD_INSERT_GAP = 3'd3,
        CMD_REMOVE     = 3'd4,
        CMD_CLEAR      = 3'd5,
        CMD_SELECT_ALL = 3'd6,
        CMD_SET_RANGE  = 3'd7
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK           = 2'd0,
        STAT_OUT_OF_RANGE = 2'd1,
        STAT_TABLE_FULL   = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_PROC,
        S_FINAL,
        S_FLUSH,
        S_RESP
    } fsm_state_t;

endpackage

/* hdl/iss_if.sv */
// Request and result channel interfaces (valid/ready plus payload).
// Depends on iss_pkg for field widths.
interface iss_req_if;
    import iss_pkg::*;
    logic               valid;
    logic               ready;
    logic [CMD_W-1:0]   command;
    logic [FIELD_W-1:0] index;
    logic [FIELD_W-1:0] count;
    logic [FIELD_W-1:0] upper_index;
    modport source (output valid, command, index, count, upper_index, input ready);
    modport sink   (input valid, command, index, count, upper_index, output ready);
endinterface

interface iss_rsp_if;
    import iss_pkg::*;
    logic                valid;
    logic                ready;
    logic                is_selected;
    logic                changed;
    logic [STATUS_W-1:0] status;
    logic [TOTAL_W-1:0]  selected_total;
    modport source (output valid, is_selected, changed, status, selected_total, input ready);
    modport sink   (input valid, is_selected, changed, status, selected_total, output ready);
endinterface

/* hdl/iss_table_mem.sv */
// Interval table storage: one write port, one read port, registered read.
// No package dependencies.
module iss_table_mem #(
    parameter int ADDR_W = 7,
    parameter int DATA_W = 48
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);
    logic [DATA_W-1:0] mem [0:(1 << ADDR_W)-1];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end
endmodule

/* hdl/interval_set_selection_table.sv */
// Top level of the interval set selection table.
// Depends on iss_pkg, iss_if (iss_req_if, iss_rsp_if) and iss_table_mem.
//
//  channel | dir | payload                                        | handshake
//  --------+-----+------------------------------------------------+----------
//  req     | in  | command, index, count, upper_index             | valid/ready
//  rsp     | out | is_selected, changed, status, selected_total   | valid/ready
//
// The single table read port streams one stored interval per cycle, except
//   that it pauses while the one interval a request may split (splits <= 1)
//   emits its second part.
// Every writing command rewrites the table into the other half of a two-bank memory;
//   the bank flips only when the command commits (no flip on a full table).
// Reset clears count, range and bank select at once; no clearing pass.
// req.ready is high only in idle; a result waiting in the output register
//   does not block the next request, only the finish of the one after it.
module interval_set_selection_table #(
    parameter int MAX_INTERVALS = 64,
    parameter int INDEX_BITS    = 24
) (
    input  logic        clk,
    input  logic        rst_n,
    iss_req_if.sink     req,
    iss_rsp_if.source   rsp
);
    import iss_pkg::*;

    localparam int IB   = INDEX_BITS;
    localparam int AW   = $clog2(MAX_INTERVALS);
    localparam int CW   = $clog2(MAX_INTERVALS + 1);
    localparam int SUMW = IB + 1;
    localparam logic [IB+1:0] GAP_LIM = (IB+2)'(1) << IB;

    // Field saturation to the index width.
    function automatic logic [IB-1:0] sat_field(input logic [FIELD_W-1:0] v);
        logic [FIELD_W+IB-1:0] ext;
        ext = (FIELD_W+IB)'(v);
        if ((ext >> IB) != '0)
            sat_field = '1;
        else
            sat_field = ext[IB-1:0];
    endfunction

    function automatic logic [TOTAL_W-1:0] sat_total(input logic [SUMW-1:0] s);
        logic [TOTAL_W+SUMW-1:0] ext;
        ext = (TOTAL_W+SUMW)'(s);
        if ((ext >> TOTAL_W) != '0)
            sat_total = '1;
        else
            sat_total = ext[TOTAL_W-1:0];
    endfunction

    // ---------------- registers ----------------
    fsm_state_t       state_reg, state_next;
    cmd_t             cmd_reg, cmd_next;
    logic [IB-1:0]    idx_reg, idx_next;
    logic [IB-1:0]    cnt_reg, cnt_next;
    logic [IB-1:0]    up_reg, up_next;
    logic             bank_reg, bank_next;
    logic [CW-1:0]    used_reg, used_next;
    logic [SUMW-1:0]  sum_reg, sum_next;
    logic [IB-1:0]    rl_reg, rl_next;
    // range high kept as high + 1, so zero means the empty reset range
    logic [IB:0]      rh_reg, rh_next;
    logic [CW-1:0]    rd_cnt_reg, rd_cnt_next;
    logic             sub_reg, sub_next;
    logic             ins_reg, ins_next;
    logic             hit_r_reg, hit_r_next;
    logic             hit_w_reg, hit_w_next;
    logic             ovf_reg, ovf_next;
    logic [CW-1:0]    wcnt_reg, wcnt_next;
    logic [SUMW-1:0]  acc_reg, acc_next;
    logic             pend_v_reg, pend_v_next;
    logic [IB-1:0]    pend_lo_reg, pend_lo_next;
    logic [IB-1:0]    pend_hi_reg, pend_hi_next;
    logic             out_v_reg, out_v_next;
    logic             out_sel_reg, out_sel_next;
    logic             out_chg_reg, out_chg_next;
    status_t          out_stat_reg, out_stat_next;
    logic [TOTAL_W-1:0] out_tot_reg, out_tot_next;

    // ---------------- memory ----------------
    logic             mem_wr_en;
    logic [AW:0]      mem_wr_addr;
    logic [2*IB-1:0]  mem_wr_data;
    logic             mem_rd_en;
    logic [AW:0]      mem_rd_addr;
    logic [2*IB-1:0]  mem_rd_data;

    iss_table_mem #(
        .ADDR_W (AW + 1),
        .DATA_W (2 * IB)
    ) u_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    // ---------------- command decode ----------------
    logic            accept;
    logic            is_sel, is_desel, is_gap, is_rem, is_clr, is_all, is_setr;
    logic            in_rng, rng_nonempty, gap_ovf, do_write, commit;
    logic [IB+1:0]   gap_sum;
    status_t         stat_now;

    assign req.ready = (state_reg == S_IDLE);
    assign accept    = req.valid & req.ready;

    always_comb
    begin
        is_sel   = (cmd_reg == CMD_SELECT);
        is_desel = (cmd_reg == CMD_DESELECT);
        is_gap   = (cmd_reg == CMD_INSERT_GAP);
        is_rem   = (cmd_reg == CMD_REMOVE);
        is_clr   = (cmd_reg == CMD_CLEAR);
        is_all   = (cmd_reg == CMD_SELECT_ALL);
        is_setr  = (cmd_reg == CMD_SET_RANGE);
        in_rng   = (idx_reg >= rl_reg) && ((IB+1)'(idx_reg) < rh_reg);
        rng_nonempty = rh_reg > (IB+1)'(rl_reg);
        gap_sum  = (IB+2)'(rh_reg) + (IB+2)'(cnt_reg);
        gap_ovf  = gap_sum > GAP_LIM;
        do_write = ((is_sel | is_desel | is_rem) & in_rng)
                 | (is_gap & (cnt_reg != '0) & !gap_ovf)
                 | is_clr | is_all | is_setr;
        commit   = do_write & !ovf_reg;

        stat_now = STAT_OK;
        if ((is_sel | is_desel | is_rem | (cmd_reg == CMD_QUERY)) && !in_rng)
            stat_now = STAT_OUT_OF_RANGE;
        else if (is_gap && (cnt_reg != '0) && gap_ovf)
            stat_now = STAT_OUT_OF_RANGE;
        else if (do_write && ovf_reg)
            stat_now = STAT_TABLE_FULL;
    end

    // ---------------- per-interval transform ----------------
    // Each stored interval yields zero, one or two intervals for the new
    // table; adjacent results are merged later in the pending stage.
    logic [IB-1:0] e_lo, e_hi;
    logic          e_has;
    logic          v1, v2, ins_set, second, more;
    logic [IB-1:0] lo1, hi1, lo2, hi2;

    assign e_lo = mem_rd_data[2*IB-1:IB];
    assign e_hi = mem_rd_data[IB-1:0];

    always_comb
    begin
        e_has   = (e_lo <= idx_reg) && (idx_reg <= e_hi);
        v1      = 1'b0;
        v2      = 1'b0;
        lo1     = e_lo;
        hi1     = e_hi;
        lo2     = e_lo;
        hi2     = e_hi;
        ins_set = 1'b0;
        case (cmd_reg)
            CMD_SELECT:
            begin
                if (!ins_reg && (idx_reg < e_lo))
                begin
                    v1      = 1'b1;
                    lo1     = idx_reg;
                    hi1     = idx_reg;
                    v2      = 1'b1;
                    ins_set = 1'b1;
                end
                else
                begin
                    v1      = 1'b1;
                    ins_set = e_has;
                end
            end
            CMD_DESELECT:
            begin
                if (e_has)
                begin
                    v1  = e_lo < idx_reg;
                    hi1 = idx_reg - IB'(1);
                    v2  = idx_reg < e_hi;
                    lo2 = idx_reg + IB'(1);
                end
                else
                begin
                    v1 = 1'b1;
                end
            end
            CMD_INSERT_GAP:
            begin
                v1 = 1'b1;
                if (e_lo >= idx_reg)
                begin
                    lo1 = e_lo + cnt_reg;
                    hi1 = e_hi + cnt_reg;
                end
                else if (e_hi >= idx_reg)
                begin
                    // split: lower part stays, upper part moves past the gap
                    hi1 = idx_reg - IB'(1);
                    v2  = 1'b1;
                    lo2 = idx_reg + cnt_reg;
                    hi2 = e_hi + cnt_reg;
                end
            end
            CMD_REMOVE:
            begin
                if (e_hi < idx_reg)
                begin
                    v1 = 1'b1;
                end
                else if (e_lo > idx_reg)
                begin
                    v1  = 1'b1;
                    lo1 = e_lo - IB'(1);
                    hi1 = e_hi - IB'(1);
                end
                else
                begin
                    v1  = e_lo != e_hi;
                    hi1 = e_hi - IB'(1);
                end
            end
            CMD_SET_RANGE:
            begin
                v1  = (e_hi >= idx_reg) && (e_lo <= up_reg) && (idx_reg <= up_reg);
                lo1 = (e_lo < idx_reg) ? idx_reg : e_lo;
                hi1 = (e_hi > up_reg) ? up_reg : e_hi;
            end
            default:
            begin
                v1 = 1'b0;
            end
        endcase
        v1     = v1 & do_write;
        v2     = v2 & do_write;
        second = v1 & v2 & !sub_reg;
        more   = (rd_cnt_reg + CW'(1)) < used_reg;
    end

    // ---------------- next state ----------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                    state_next = S_START;
            end
            S_START:
            begin
                state_next = (used_reg == '0) ? S_FINAL : S_PROC;
            end
            S_PROC:
            begin
                if (!second && !more)
                    state_next = S_FINAL;
            end
            S_FINAL:
            begin
                state_next = S_FLUSH;
            end
            S_FLUSH:
            begin
                state_next = S_RESP;
            end
            S_RESP:
            begin
                if (!out_v_reg || rsp.ready)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // ---------------- datapath and outputs ----------------
    logic          push_v, flush, merge, emit;
    logic [IB-1:0] push_lo, push_hi;

    always_comb
    begin
        cmd_next      = cmd_reg;
        idx_next      = idx_reg;
        cnt_next      = cnt_reg;
        up_next       = up_reg;
        bank_next     = bank_reg;
        used_next     = used_reg;
        sum_next      = sum_reg;
        rl_next       = rl_reg;
        rh_next       = rh_reg;
        rd_cnt_next   = rd_cnt_reg;
        sub_next      = sub_reg;
        ins_next      = ins_reg;
        hit_r_next    = hit_r_reg;
        hit_w_next    = hit_w_reg;
        ovf_next      = ovf_reg;
        wcnt_next     = wcnt_reg;
        acc_next      = acc_reg;
        pend_v_next   = pend_v_reg;
        pend_lo_next  = pend_lo_reg;
        pend_hi_next  = pend_hi_reg;
        out_v_next    = out_v_reg & !rsp.ready;
        out_sel_next  = out_sel_reg;
        out_chg_next  = out_chg_reg;
        out_stat_next = out_stat_reg;
        out_tot_next  = out_tot_reg;
        mem_rd_en     = 1'b0;
        mem_rd_addr   = {bank_reg, rd_cnt_reg[AW-1:0]};
        mem_wr_en     = 1'b0;
        mem_wr_addr   = {~bank_reg, wcnt_reg[AW-1:0]};
        mem_wr_data   = {pend_lo_reg, pend_hi_reg};
        push_v        = 1'b0;
        push_lo       = '0;
        push_hi       = '0;
        flush         = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd_next = cmd_t'(req.command);
                    idx_next = sat_field(req.index);
                    cnt_next = sat_field(req.count);
                    up_next  = sat_field(req.upper_index);
                end
            end
            S_START:
            begin
                rd_cnt_next = '0;
                sub_next    = 1'b0;
                ins_next    = 1'b0;
                hit_r_next  = 1'b0;
                hit_w_next  = 1'b0;
                ovf_next    = 1'b0;
                wcnt_next   = '0;
                acc_next    = '0;
                pend_v_next = 1'b0;
                mem_rd_en   = (used_reg != '0);
                mem_rd_addr = {bank_reg, {AW{1'b0}}};
            end
            S_PROC:
            begin
                hit_r_next = hit_r_reg | e_has;
                ins_next   = ins_reg | ins_set;
                if (sub_reg)
                begin
                    push_v  = 1'b1;
                    push_lo = lo2;
                    push_hi = hi2;
                end
                else
                begin
                    push_v  = v1 | v2;
                    push_lo = v1 ? lo1 : lo2;
                    push_hi = v1 ? hi1 : hi2;
                end
                if (second)
                begin
                    sub_next = 1'b1;
                end
                else
                begin
                    sub_next = 1'b0;
                    if (more)
                    begin
                        rd_cnt_next = rd_cnt_reg + CW'(1);
                        mem_rd_en   = 1'b1;
                        mem_rd_addr = {bank_reg, rd_cnt_next[AW-1:0]};
                    end
                end
            end
            S_FINAL:
            begin
                // select of an index beyond every interval, or the whole range
                if (is_sel && do_write && !ins_reg)
                begin
                    push_v  = 1'b1;
                    push_lo = idx_reg;
                    push_hi = idx_reg;
                end
                else if (is_all && rng_nonempty)
                begin
                    push_v  = 1'b1;
                    push_lo = rl_reg;
                    push_hi = IB'(rh_reg - (IB+1)'(1));
                end
            end
            S_FLUSH:
            begin
                flush = 1'b1;
            end
            S_RESP:
            begin
                if (!out_v_reg || rsp.ready)
                begin
                    out_v_next    = 1'b1;
                    out_sel_next  = commit ? hit_w_reg : hit_r_reg;
                    out_chg_next  = commit & ((is_sel & !hit_r_reg) | (is_desel & hit_r_reg));
                    out_stat_next = stat_now;
                    out_tot_next  = sat_total(commit ? acc_reg : sum_reg);
                    if (commit)
                    begin
                        bank_next = ~bank_reg;
                        used_next = wcnt_reg;
                        sum_next  = acc_reg;
                        if (is_gap)
                            rh_next = gap_sum[IB:0];
                        else if (is_rem)
                            rh_next = rh_reg - (IB+1)'(1);
                        else if (is_setr)
                        begin
                            rl_next = idx_reg;
                            rh_next = (IB+1)'(up_reg) + (IB+1)'(1);
                        end
                    end
                end
            end
            default:
            begin
                flush = 1'b0;
            end
        endcase

        // Pending stage: merges touching intervals, writes the finished one.
        merge = pend_v_reg &&
                (((IB+1)'(pend_hi_reg) + (IB+1)'(1)) == (IB+1)'(push_lo));
        emit  = push_v ? (pend_v_reg & !merge) : (flush & pend_v_reg);
        if (emit)
        begin
            if (wcnt_reg < CW'(MAX_INTERVALS))
            begin
                mem_wr_en  = 1'b1;
                wcnt_next  = wcnt_reg + CW'(1);
                acc_next   = acc_reg + SUMW'(pend_hi_reg - pend_lo_reg) + SUMW'(1);
                hit_w_next = hit_w_reg |
                             ((pend_lo_reg <= idx_reg) && (idx_reg <= pend_hi_reg));
            end
            else
            begin
                ovf_next = 1'b1;
            end
        end
        if (push_v)
        begin
            pend_v_next  = 1'b1;
            pend_hi_next = push_hi;
            if (!merge)
                pend_lo_next = push_lo;
        end
        else if (flush)
        begin
            pend_v_next = 1'b0;
        end
    end

    assign rsp.valid          = out_v_reg;
    assign rsp.is_selected    = out_sel_reg;
    assign rsp.changed        = out_chg_reg;
    assign rsp.status         = out_stat_reg;
    assign rsp.selected_total = out_tot_reg;

    // ---------------- registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            bank_reg  <= 1'b0;
            used_reg  <= '0;
            sum_reg   <= '0;
            rl_reg    <= '0;
            rh_reg    <= '0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            bank_reg  <= bank_next;
            used_reg  <= used_next;
            sum_reg   <= sum_next;
            rl_reg    <= rl_next;
            rh_reg    <= rh_next;
            out_v_reg <= out_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        idx_reg      <= idx_next;
        cnt_reg      <= cnt_next;
        up_reg       <= up_next;
        rd_cnt_reg   <= rd_cnt_next;
        sub_reg      <= sub_next;
        ins_reg      <= ins_next;
        hit_r_reg    <= hit_r_next;
        hit_w_reg    <= hit_w_next;
        ovf_reg      <= ovf_next;
        wcnt_reg     <= wcnt_next;
        acc_reg      <= acc_next;
        pend_v_reg   <= pend_v_next;
        pend_lo_reg  <= pend_lo_next;
        pend_hi_reg  <= pend_hi_next;
        out_sel_reg  <= out_sel_next;
        out_chg_reg  <= out_chg_next;
        out_stat_reg <= out_stat_next;
        out_tot_reg  <= out_tot_next;
    end

`ifndef SYNTHESIS
    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= CW'(MAX_INTERVALS))
        else $error("interval count above table size");

    a_wr_bound: assert property (@(posedge clk) disable iff (!rst_n)
        mem_wr_en |-> (wcnt_reg < CW'(MAX_INTERVALS)))
        else $error("table write past last entry");

    a_rd_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PROC) |-> (rd_cnt_reg < used_reg))
        else $error("table read past last interval");

    a_result_out: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RESP && state_next == S_IDLE) |=> rsp.valid)
        else $error("finished request left no result");
`endif
endmodule

/* tb/tb_interval_set_selection_table.sv */
// Self-checking testbench for interval_set_selection_table.
// Depends on iss_pkg and iss_if (iss_req_if, iss_rsp_if); predicts each result in-line.
module tb_interval_set_selection_table;
    import iss_pkg::*;

    localparam int TABLE_DEPTH = 64;
    localparam longint IDX_TOP = 64'hFF_FFFF;
    localparam longint TOTAL_TOP = 64'h1FF_FFFF;
    localparam int STALL_LIMIT = 3000;  // idle cycles before the watchdog fires
    localparam int RANDOM_ITEMS = 1300;

    typedef struct {
        cmd_t        cmd;
        logic [23:0] idx;
        logic [23:0] cnt;
        logic [23:0] up;
        bit          wait_drain;  // hold this request until every result is back
    } request_t;

    typedef struct {
        bit          sel;
        bit          chg;
        status_t     st;
        logic [24:0] total;
    } outcome_t;

    logic clk;
    logic rst_n;

    iss_req_if req ();
    iss_rsp_if rsp ();

    interval_set_selection_table u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.sink),
        .rsp   (rsp.source)
    );

    // ------------------------------------------------------------------
    // Shadow copy of the selection table
    // ------------------------------------------------------------------
    longint span_lo [TABLE_DEPTH];
    longint span_hi [TABLE_DEPTH];
    int     spans_used;
    longint sel_count;
    longint win_lo;
    longint win_hi;  // window empty while win_hi < win_lo

    request_t pending_reqs[$];
    outcome_t expected_outcomes[$];

    int errors;
    int cmd_seen [8];
    int full_seen;
    int oor_seen;
    int results_checked;

    // first span whose upper end is not below v
    function automatic int locate(longint v);
        int n;
        n = 0;
        while (n < spans_used && v > span_hi[n])
            n++;
        return n;
    endfunction

    function automatic bit covers(int p, longint v);
        return p < spans_used && span_lo[p] <= v && v <= span_hi[p];
    endfunction

    function automatic void open_slot(int p, longint lo, longint hi);
        for (int k = spans_used; k > p; k--)
        begin
            span_lo[k] = span_lo[k-1];
            span_hi[k] = span_hi[k-1];
        end
        span_lo[p] = lo;
        span_hi[p] = hi;
        spans_used++;
    endfunction

    function automatic void close_slot(int p);
        for (int k = p; k < spans_used - 1; k++)
        begin
            span_lo[k] = span_lo[k+1];
            span_hi[k] = span_hi[k+1];
        end
        spans_used--;
    endfunction

    function automatic void merge_next(int a);
        if (a + 1 < spans_used && span_hi[a] + 1 == span_lo[a+1])
        begin
            span_hi[a] = span_hi[a+1];
            close_slot(a + 1);
        end
    endfunction

    function automatic outcome_t apply_request(request_t r);
        outcome_t o;
        longint idx;
        longint cnt;
        longint up;
        int p;
        bit in_win;
        idx = longint'(r.idx);
        cnt = longint'(r.cnt);
        up  = longint'(r.up);
        o.chg = 1'b0;
        o.st  = STAT_OK;
        in_win = (idx >= win_lo && idx <= win_hi);
        case (r.cmd)
            CMD_SELECT:
            begin
                if (!in_win)
                    o.st = STAT_OUT_OF_RANGE;
                else
                begin
                    p = locate(idx);
                    if (!covers(p, idx))
                    begin
                        if (p > 0 && span_hi[p-1] == idx - 1)
                        begin
                            span_hi[p-1] = idx;
                            merge_next(p - 1);
                            o.chg = 1'b1;
                        end
                        else if (p < spans_used && span_lo[p] == idx + 1)
                        begin
                            span_lo[p] = idx;
                            o.chg = 1'b1;
                        end
                        else if (spans_used >= TABLE_DEPTH)
                            o.st = STAT_TABLE_FULL;
                        else
                        begin
                            open_slot(p, idx, idx);
                            o.chg = 1'b1;
                        end
                        if (o.chg)
                            sel_count++;
                    end
                end
            end
            CMD_DESELECT:
            begin
                if (!in_win)
                    o.st = STAT_OUT_OF_RANGE;
                else
                begin
                    p = locate(idx);
                    if (covers(p, idx))
                    begin
                        o.chg = 1'b1;
                        if (span_lo[p] == idx && span_hi[p] == idx)
                            close_slot(p);
                        else if (span_lo[p] == idx)
                            span_lo[p] = idx + 1;
                        else if (span_hi[p] == idx)
                            span_hi[p] = idx - 1;
                        else if (spans_used >= TABLE_DEPTH)
                        begin
                            o.st  = STAT_TABLE_FULL;
                            o.chg = 1'b0;
                        end
                        else
                        begin
                            open_slot(p, span_lo[p], idx - 1);
                            span_lo[p+1] = idx + 1;
                        end
                        if (o.chg)
                            sel_count--;
                    end
                end
            end
            CMD_QUERY:
            begin
                if (!in_win)
                    o.st = STAT_OUT_OF_RANGE;
            end
            CMD_INSERT_GAP:
            begin
                if (cnt != 0)
                begin
                    if (win_hi + cnt > IDX_TOP)
                        o.st = STAT_OUT_OF_RANGE;
                    else
                    begin
                        p = locate(idx);
                        if (covers(p, idx) && span_lo[p] != idx)
                        begin
                            if (spans_used >= TABLE_DEPTH)
                                o.st = STAT_TABLE_FULL;
                            else
                            begin
                                // split so the upper part can slide up
                                open_slot(p, span_lo[p], idx - 1);
                                p++;
                                span_lo[p] = idx;
                            end
                        end
                        if (o.st == STAT_OK)
                        begin
                            for (int n = p; n < spans_used; n++)
                            begin
                                span_lo[n] += cnt;
                                span_hi[n] += cnt;
                            end
                            win_hi += cnt;
                        end
                    end
                end
            end
            CMD_REMOVE:
            begin
                if (!in_win)
                    o.st = STAT_OUT_OF_RANGE;
                else
                begin
                    p = locate(idx);
                    if (covers(p, idx))
                    begin
                        if (span_lo[p] == span_hi[p])
                            close_slot(p);
                        else
                        begin
                            span_hi[p]--;
                            p++;
                        end
                        sel_count--;
                    end
                    for (int n = p; n < spans_used; n++)
                    begin
                        span_lo[n]--;
                        span_hi[n]--;
                    end
                    if (p > 0)
                        merge_next(p - 1);
                    win_hi--;
                end
            end
            CMD_CLEAR:
            begin
                spans_used = 0;
                sel_count  = 0;
            end
            CMD_SELECT_ALL:
            begin
                spans_used = 0;
                sel_count  = 0;
                if (win_hi >= win_lo)
                begin
                    span_lo[0] = win_lo;
                    span_hi[0] = win_hi;
                    spans_used = 1;
                    sel_count  = win_hi - win_lo + 1;
                end
            end
            default:
            begin  // CMD_SET_RANGE: trim both ends, then recount
                win_lo = idx;
                win_hi = up;
                while (spans_used > 0 && span_hi[0] < win_lo)
                    close_slot(0);
                if (spans_used > 0 && span_lo[0] < win_lo)
                    span_lo[0] = win_lo;
                while (spans_used > 0 && span_lo[spans_used-1] > win_hi)
                    close_slot(spans_used - 1);
                if (spans_used > 0 && span_hi[spans_used-1] > win_hi)
                    span_hi[spans_used-1] = win_hi;
                sel_count = 0;
                for (int n = 0; n < spans_used; n++)
                    sel_count += span_hi[n] - span_lo[n] + 1;
            end
        endcase
        o.sel = covers(locate(idx), idx);
        o.total = (sel_count < 0) ? 25'd0 :
                  (sel_count > TOTAL_TOP) ? 25'h1FF_FFFF : sel_count[24:0];
        return o;
    endfunction

    // ------------------------------------------------------------------
    // Clock and reset
    // ------------------------------------------------------------------
    initial clk = 1'b0;
    always #5 clk = ~clk;

    initial
    begin
        rst_n = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
    end

    // ------------------------------------------------------------------
    // Request driver: pops pending requests, random gap before each one.
    // ------------------------------------------------------------------
    int  gap_left;
    int  drv_sent;

    always @(posedge clk or negedge rst_n)
    begin
        request_t nxt;
        request_t cur;
        outcome_t pred;
        bit       busy;
        bit       may_send;
        if (!rst_n)
        begin
            req.valid       <= 1'b0;
            req.command     <= '0;
            req.index       <= '0;
            req.count       <= '0;
            req.upper_index <= '0;
            gap_left        = 0;
            drv_sent        = 0;
            spans_used      = 0;
            sel_count       = 0;
            win_lo          = 0;
            win_hi          = -1;
        end
        else
        begin
            busy = req.valid;
            if (req.valid && req.ready)
            begin
                cur.cmd = cmd_t'(req.command);
                cur.idx = req.index;
                cur.cnt = req.count;
                cur.up  = req.upper_index;
                cur.wait_drain = 1'b0;
                pred = apply_request(cur);
                expected_outcomes.insert(expected_outcomes.size(), pred);
                cmd_seen[req.command]++;
                busy = 1'b0;
                drv_sent++;
                gap_left = $urandom_range(0, 4);
            end
            if (!busy)
            begin
                may_send = pending_reqs.size() > 0;
                if (may_send)
                    may_send = !pending_reqs[0].wait_drain ||
                               expected_outcomes.size() == 0;
                if (gap_left > 0)
                begin
                    gap_left--;
                    req.valid <= 1'b0;
                end
                else if (may_send)
                begin
                    nxt = pending_reqs.pop_front();
                    req.command     <= nxt.cmd;
                    req.index       <= nxt.idx;
                    req.count       <= nxt.cnt;
                    req.upper_index <= nxt.up;
                    req.valid       <= 1'b1;
                end
                else
                    req.valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result monitor: random back-pressure, field-by-field compare, watchdog
    // ------------------------------------------------------------------
    int stall_left;
    int idle_cycles;
    int mon_taken;

    always @(posedge clk or negedge rst_n)
    begin
        outcome_t exp_o;
        if (!rst_n)
        begin
            rsp.ready   <= 1'b0;
            stall_left  = 0;
            idle_cycles = 0;
            mon_taken   = 0;
        end
        else
        begin
            if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
                $display("interval_set_selection_table: mismatch");
                $finish;
            end
            if (rsp.valid && rsp.ready)
            begin
                mon_taken++;
                if (expected_outcomes.size() == 0)
                begin
                    $error("result with no request outstanding");
                    errors++;
                end
                else
                begin
                    exp_o = expected_outcomes.pop_front();
                    results_checked++;
                    if (rsp.is_selected !== exp_o.sel)
                    begin
                        $error("is_selected: expected %0d got %0d", exp_o.sel, rsp.is_selected);
                        errors++;
                    end
                    if (rsp.changed !== exp_o.chg)
                    begin
                        $error("changed: expected %0d got %0d", exp_o.chg, rsp.changed);
                        errors++;
                    end
                    if (rsp.status !== exp_o.st)
                    begin
                        $error("status: expected %0d got %0d", exp_o.st, rsp.status);
                        errors++;
                    end
                    if (rsp.selected_total !== exp_o.total)
                    begin
                        $error("selected_total: expected %0d got %0d",
                               exp_o.total, rsp.selected_total);
                        errors++;
                    end
                    if (exp_o.st == STAT_TABLE_FULL)
                        full_seen++;
                    if (exp_o.st == STAT_OUT_OF_RANGE)
                        oor_seen++;
                end
                stall_left = $urandom_range(0, 4);
            end
            if (stall_left > 0)
            begin
                stall_left--;
                rsp.ready <= 1'b0;
            end
            else
                rsp.ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    int queued;

    task automatic add_req(cmd_t c, logic [23:0] i, logic [23:0] n,
                           logic [23:0] u, bit drain = 1'b0);
        request_t r;
        r.cmd = c;
        r.idx = i;
        r.cnt = n;
        r.up  = u;
        r.wait_drain = drain;
        pending_reqs.insert(pending_reqs.size(), r);
        queued++;
    endtask

    // dense triples of selected indexes until the table overflows,
    // then full-table deselect split and insert-gap split
    task automatic fill_table(logic [23:0] b);
        add_req(CMD_SET_RANGE, b, 0, b + 24'd300);
        add_req(CMD_CLEAR, b, 0, 0);
        for (int k = 0; k <= TABLE_DEPTH; k++)
            for (int j = 0; j < 3; j++)
                add_req(CMD_SELECT, b + 24'(4 * k + j), 0, 0);
        add_req(CMD_DESELECT, b + 24'd5, 0, 0);
        add_req(CMD_INSERT_GAP, b + 24'd9, 24'd2, 0);
        add_req(CMD_SELECT, b + 24'd3, 0, 0);       // bridges two triples
        add_req(CMD_DESELECT, b + 24'd5, 0, 0);     // now a split fits
        add_req(CMD_REMOVE, b + 24'd11, 0, 0);      // unselected gap closes up
        add_req(CMD_QUERY, b + 24'd12, 0, 0);
    endtask

    initial
    begin
        logic [23:0] base;
        logic [23:0] w;
        logic [23:0] idx;
        logic [23:0] cnt;
        int          pick;
        int          fills;
        bit          drain_done;
        errors = 0;
        full_seen = 0;
        oor_seen = 0;
        results_checked = 0;
        queued = 0;
        fills = 0;
        drain_done = 1'b0;
        foreach (cmd_seen[k])
            cmd_seen[k] = 0;

        // directed: empty range after reset, merges, splits, shifts, edges
        add_req(CMD_QUERY, 24'd0, 0, 0);
        add_req(CMD_SELECT, 24'd5, 0, 0);
        add_req(CMD_SELECT_ALL, 24'd0, 0, 0);
        add_req(CMD_SET_RANGE, 24'd10, 0, 24'd40);
        add_req(CMD_SELECT, 24'd10, 0, 0);
        add_req(CMD_SELECT, 24'd12, 0, 0);
        add_req(CMD_SELECT, 24'd11, 0, 0);
        add_req(CMD_SELECT, 24'd11, 0, 0);
        add_req(CMD_SELECT, 24'd40, 0, 0);
        add_req(CMD_SELECT, 24'd41, 0, 0);
        add_req(CMD_DESELECT, 24'd11, 0, 0);
        add_req(CMD_DESELECT, 24'd9, 0, 0);
        add_req(CMD_INSERT_GAP, 24'd12, 24'd0, 0);
        add_req(CMD_INSERT_GAP, 24'd20, 24'hFF_FFFF, 0);
        add_req(CMD_INSERT_GAP, 24'd1000, 24'd3, 0);
        add_req(CMD_SELECT, 24'd14, 0, 0);
        add_req(CMD_REMOVE, 24'd13, 0, 0);
        add_req(CMD_REMOVE, 24'd43, 0, 0);
        add_req(CMD_CLEAR, 24'd10, 0, 0);
        add_req(CMD_SELECT_ALL, 24'd20, 0, 0);
        add_req(CMD_SET_RANGE, 24'd50, 0, 24'd49);
        add_req(CMD_SELECT_ALL, 24'd50, 0, 0);
        add_req(CMD_SET_RANGE, 24'hFF_FFF0, 0, 24'hFF_FFFF);
        add_req(CMD_SELECT_ALL, 24'hFF_FFFF, 0, 0);
        add_req(CMD_INSERT_GAP, 24'hFF_FFF8, 24'd1, 0);

        // random: set a window, then a batch of operations mostly inside it
        while (queued < RANDOM_ITEMS)
        begin
            if (fills < 3 && $urandom_range(0, 9) == 0)
            begin
                fill_table(24'($urandom_range(0, 20000)));
                fills++;
                continue;
            end
            w = ($urandom_range(0, 9) < 7) ? 24'($urandom_range(0, 60))
                                           : 24'($urandom_range(0, 300));
            pick = $urandom_range(0, 9);
            if (pick < 8)
                base = 24'($urandom_range(0, 1000));
            else if (pick == 8)
                base = 24'hFF_FFFF - w - 24'($urandom_range(0, 5));
            else
                base = 24'($urandom);
            add_req(CMD_SET_RANGE, base, 24'($urandom), base + w);
            repeat ($urandom_range(10, 60))
            begin
                idx = base + 24'($urandom_range(0, w + 2)) - 24'd1;
                cnt = ($urandom_range(0, 9) == 0) ? 24'($urandom)
                                                  : 24'($urandom_range(0, 5));
                pick = $urandom_range(0, 99);
                if (!drain_done && queued >= 700)
                begin
                    add_req(CMD_QUERY, idx, cnt, 0, 1'b1);
                    drain_done = 1'b1;
                end
                else if (pick < 35)
                    add_req(CMD_SELECT, idx, cnt, 24'($urandom));
                else if (pick < 55)
                    add_req(CMD_DESELECT, idx, cnt, 24'($urandom));
                else if (pick < 63)
                    add_req(CMD_QUERY, idx, cnt, 24'($urandom));
                else if (pick < 71)
                    add_req(CMD_INSERT_GAP, idx, cnt, 24'($urandom));
                else if (pick < 83)
                    add_req(CMD_REMOVE, idx, cnt, 24'($urandom));
                else if (pick < 85)
                    add_req(CMD_CLEAR, idx, cnt, 24'($urandom));
                else if (pick < 88)
                    add_req(CMD_SELECT_ALL, idx, cnt, 24'($urandom));
                else if (pick < 90)
                    add_req(CMD_SET_RANGE, idx, cnt, idx + 24'($urandom_range(0, 40)));
                else  // noise: any command, any field values
                    add_req(cmd_t'($urandom_range(0, 7)), 24'($urandom),
                            24'($urandom), 24'($urandom));
            end
        end

        // drain, then allow for a request still in flight
        wait (rst_n === 1'b1);
        while (pending_reqs.size() > 0 || req.valid === 1'b1 || expected_outcomes.size() > 0)
            @(posedge clk);
        repeat (100) @(posedge clk);

        $display("covered %0d requests (%0d select, %0d deselect, %0d remove, %0d gap)",
                 drv_sent, cmd_seen[CMD_SELECT], cmd_seen[CMD_DESELECT],
                 cmd_seen[CMD_REMOVE], cmd_seen[CMD_INSERT_GAP]);
        $display("results checked %0d, table-full %0d, out-of-range %0d, errors %0d",
                 results_checked, full_seen, oor_seen, errors);
        if (errors == 0 && expected_outcomes.size() == 0)
            $display("interval_set_selection_table: match");
        else
            $display("interval_set_selection_table: mismatch");
        $finish;
    end

endmodule
